### hw/rtl/trsm_pkg.sv
// Shared types, constants and codes of the transport receive session manager.
package trsm_pkg;

    localparam int SessionsDefault = 3;
    localparam logic [17:0] GroupReset = 18'd65291;

    localparam logic [1:0] ACT_RTS   = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_ABORT = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic [2:0] KIND_CTS     = 3'd0;
    localparam logic [2:0] KIND_ACK     = 3'd1;
    localparam logic [2:0] KIND_ABORT   = 3'd2;
    localparam logic [2:0] KIND_WRITE   = 3'd3;
    localparam logic [2:0] KIND_REL_OK  = 3'd4;
    localparam logic [2:0] KIND_REL_BAD = 3'd5;
    localparam logic [2:0] KIND_SERVICE = 3'd6;

    localparam logic [1:0] RSN_BUSY     = 2'd0;
    localparam logic [1:0] RSN_RESOURCE = 2'd1;
    localparam logic [1:0] RSN_TIMEOUT  = 2'd2;

    localparam logic [2:0] ST_INACTIVE = 3'd0;
    localparam logic [2:0] ST_CTS      = 3'd1;
    localparam logic [2:0] ST_DATA     = 3'd2;
    localparam logic [2:0] ST_ACK      = 3'd3;
    localparam logic [2:0] ST_IABORT   = 3'd4;
    localparam logic [2:0] ST_XABORT   = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  slot;
        logic [7:0]  peer_addr;
        logic [17:0] group_number;
        logic [15:0] total_bytes;
        logic [7:0]  total_packets;
        logic [7:0]  max_per_window;
        logic [7:0]  seq_num;
        logic [55:0] packet_data;
        logic        buffer_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [1:0]  out_slot;
        logic [7:0]  dest_addr;
        logic [17:0] out_group_number;
        logic [15:0] word_a;
        logic [7:0]  word_b;
        logic [1:0]  abort_reason;
        logic [55:0] write_data;
        logic        last;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture the input item
        logic decide;   // evaluate the item and update the session table
        logic pop;      // advance to the next queued result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic has_result;  // a queued result is available
    } t_status;

endpackage

### hw/rtl/trsm_stream_if.sv
// Valid/ready channel interfaces for input items and result items.
interface trsm_in_if;
    logic                 valid;
    logic                 ready;
    trsm_pkg::t_in_item   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface trsm_out_if;
    logic                 valid;
    logic                 ready;
    trsm_pkg::t_out_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/trsm_datapath.sv
// Session table, item evaluation and result queue.
module trsm_datapath #(
    parameter int SESSIONS = trsm_pkg::SessionsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [17:0]         i_accepted_group,
    input  trsm_pkg::t_in_item  i_item,
    input  trsm_pkg::t_cmd      i_cmd,
    output trsm_pkg::t_status   o_status,
    output trsm_pkg::t_out_item o_result
);
    localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    trsm_pkg::t_in_item r_item;

    logic [2:0]  r_state  [SESSIONS];
    logic [SESSIONS-1:0] r_seen;
    logic [7:0]  r_peer   [SESSIONS];
    logic [17:0] r_group  [SESSIONS];
    logic [15:0] r_bytes  [SESSIONS];
    logic [7:0]  r_pkts   [SESSIONS];
    logic [7:0]  r_wmax   [SESSIONS];
    logic [7:0]  r_wcnt   [SESSIONS];
    logic [7:0]  r_wlast  [SESSIONS];
    logic [7:0]  r_exp    [SESSIONS];

    trsm_pkg::t_out_item r_q [3];
    logic [1:0] r_qn;
    logic [1:0] r_qp;

    // Combinational evaluation of the captured item.
    logic        f_peer_hit, f_free_hit;
    logic [SW-1:0] f_peer, f_free;
    logic [7:0]  ceil7;
    logic        bad_req;
    logic [SW-1:0] tslot;
    logic        tslot_ok;

    always_comb begin
        f_peer_hit = 1'b0;
        f_free_hit = 1'b0;
        f_peer = '0;
        f_free = '0;
        for (int k = SESSIONS - 1; k >= 0; k--) begin
            if (r_state[k] != trsm_pkg::ST_INACTIVE && r_peer[k] == r_item.peer_addr) begin
                f_peer_hit = 1'b1;
                f_peer = SW'(k);
            end
            if (r_state[k] == trsm_pkg::ST_INACTIVE) begin
                f_free_hit = 1'b1;
                f_free = SW'(k);
            end
        end
    end

    // ceil(bytes/7) by reciprocal: floor(x/7) = (x*9363)>>16 is exact for x < 13107.
    // Larger sums can read one high, but their true quotient is already above 255.
    logic [16:0] bplus;
    logic [32:0] prod;
    always_comb begin
        bplus = {1'b0, r_item.total_bytes} + 17'd6;
        prod  = 33'(bplus) * 33'd9363;
        // Upper bound check: result above 255 cannot match an 8-bit count.
        ceil7 = prod[23:16];
        bad_req = (r_item.total_bytes == '0) || (r_item.total_packets == '0) ||
                  (r_item.max_per_window == '0) || (prod[32:24] != '0) ||
                  (ceil7 != r_item.total_packets);
        tslot_ok = ({30'd0, r_item.slot} < 32'(SESSIONS));
        tslot = SW'(r_item.slot);
    end

    function automatic trsm_pkg::t_out_item mk(
        input logic [2:0] kind, input logic [1:0] sl, input logic [7:0] d,
        input logic [17:0] g, input logic [15:0] a, input logic [7:0] b,
        input logic [1:0] rs, input logic [55:0] wd);
        trsm_pkg::t_out_item r;
        r.out_kind = kind; r.out_slot = sl; r.dest_addr = d;
        r.out_group_number = g; r.word_a = a; r.word_b = b;
        r.abort_reason = rs; r.write_data = wd; r.last = 1'b0;
        return r;
    endfunction

    // Data packet arithmetic for the matched session.
    logic [15:0] loc;
    logic [15:0] raw_loc;
    logic [7:0]  wlen;
    logic [7:0]  d_cnt;
    logic [7:0]  d_rem;
    logic [7:0]  nexp;
    always_comb begin
        raw_loc = (r_item.seq_num == '0) ? 16'd0 :
                  16'((r_item.seq_num - 8'd1)) * 16'd7;
        loc = (raw_loc > r_bytes[f_peer]) ? r_bytes[f_peer] : raw_loc;
        wlen = (r_item.seq_num < r_pkts[f_peer]) ? 8'd7 : 8'(r_bytes[f_peer] - loc);
        nexp = r_exp[f_peer] + 8'd1;
        d_rem = r_pkts[f_peer] - nexp + 8'd1;
        d_cnt = (r_wmax[f_peer] < d_rem) ? r_wmax[f_peer] : d_rem;
    end

    // Window for a new request.
    logic [7:0] q_cnt;
    always_comb begin
        q_cnt = (r_item.max_per_window < r_item.total_packets) ?
                r_item.max_per_window : r_item.total_packets;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn <= '0;
            r_qp <= '0;
            r_seen <= '0;
            for (int k = 0; k < SESSIONS; k++) r_state[k] <= trsm_pkg::ST_INACTIVE;
        end else begin
            if (i_cmd.load) begin
                r_item <= i_item;
                r_qn <= '0;
                r_qp <= '0;
            end
            if (i_cmd.pop) r_qp <= r_qp + 2'd1;
            if (i_cmd.decide) begin : dec
                logic [1:0] n;
                logic [1:0] ps;
                logic [2:0] st;
                n = '0;
                ps = 2'(f_peer);
                unique case (r_item.action)
                    trsm_pkg::ACT_RTS: begin
                        if (bad_req) begin
                            r_q[0] <= mk(trsm_pkg::KIND_ABORT, 2'd0, r_item.peer_addr,
                                r_item.group_number, '0, '0, trsm_pkg::RSN_RESOURCE, '0);
                            n = 2'd1;
                        end else if (f_peer_hit) begin
                            r_q[0] <= mk(trsm_pkg::KIND_ABORT, 2'd0, r_item.peer_addr,
                                r_item.group_number, '0, '0, trsm_pkg::RSN_BUSY, '0);
                            n = 2'd1;
                        end else if (r_item.group_number == i_accepted_group && f_free_hit
                                     && r_item.buffer_ok) begin
                            r_peer[f_free]  <= r_item.peer_addr;
                            r_group[f_free] <= r_item.group_number;
                            r_bytes[f_free] <= r_item.total_bytes;
                            r_pkts[f_free]  <= r_item.total_packets;
                            r_wmax[f_free]  <= r_item.max_per_window;
                            r_exp[f_free]   <= 8'd1;
                            r_wcnt[f_free]  <= q_cnt;
                            r_wlast[f_free] <= q_cnt;
                            r_state[f_free] <= trsm_pkg::ST_CTS;
                            r_q[0] <= mk(trsm_pkg::KIND_SERVICE, 2'(f_free), r_item.peer_addr,
                                r_item.group_number, '0, '0, '0, '0);
                            n = 2'd1;
                        end else begin
                            r_q[0] <= mk(trsm_pkg::KIND_ABORT, 2'd0, r_item.peer_addr,
                                r_item.group_number, '0, '0, trsm_pkg::RSN_RESOURCE, '0);
                            n = 2'd1;
                        end
                    end
                    trsm_pkg::ACT_DATA: begin
                        if (f_peer_hit && r_state[f_peer] == trsm_pkg::ST_DATA) begin
                            logic keep;
                            logic [7:0] ex;
                            keep = 1'b1;
                            ex = r_exp[f_peer];
                            st = trsm_pkg::ST_DATA;
                            r_seen[f_peer] <= 1'b1;
                            if (r_item.seq_num == r_exp[f_peer]) begin
                                r_q[0] <= mk(trsm_pkg::KIND_WRITE, ps, r_item.peer_addr,
                                    r_group[f_peer], loc, wlen, '0, r_item.packet_data);
                                n = 2'd1;
                                keep = r_item.buffer_ok;
                                ex = nexp;
                                r_exp[f_peer] <= nexp;
                            end
                            if (!keep) begin
                                r_q[n] <= mk(trsm_pkg::KIND_REL_BAD, ps, r_item.peer_addr,
                                    r_group[f_peer], '0, '0, '0, '0);
                                n = n + 2'd1;
                                st = trsm_pkg::ST_IABORT;
                            end else if (r_item.seq_num >= r_pkts[f_peer]) begin
                                r_q[n] <= mk(trsm_pkg::KIND_REL_OK, ps, r_item.peer_addr,
                                    r_group[f_peer], '0, '0, '0, '0);
                                n = n + 2'd1;
                                st = trsm_pkg::ST_ACK;
                            end else if (r_item.seq_num >= r_wlast[f_peer]) begin
                                // Window opens at the (possibly advanced) expected sequence.
                                if (ex == nexp) begin
                                    r_wcnt[f_peer]  <= d_cnt;
                                    r_wlast[f_peer] <= ex + d_cnt - 8'd1;
                                end else begin
                                    r_wcnt[f_peer]  <= (r_wmax[f_peer] < (r_pkts[f_peer] - ex + 8'd1))
                                        ? r_wmax[f_peer] : (r_pkts[f_peer] - ex + 8'd1);
                                    r_wlast[f_peer] <= ex - 8'd1 +
                                        ((r_wmax[f_peer] < (r_pkts[f_peer] - ex + 8'd1))
                                        ? r_wmax[f_peer] : (r_pkts[f_peer] - ex + 8'd1));
                                end
                                st = trsm_pkg::ST_CTS;
                            end
                            r_state[f_peer] <= st;
                            if (st != trsm_pkg::ST_DATA) begin
                                r_q[n] <= mk(trsm_pkg::KIND_SERVICE, ps, r_item.peer_addr,
                                    r_group[f_peer], '0, '0, '0, '0);
                                n = n + 2'd1;
                            end
                        end
                    end
                    trsm_pkg::ACT_ABORT: begin
                        if (f_peer_hit && r_group[f_peer] == r_item.group_number) begin
                            r_q[0] <= mk(trsm_pkg::KIND_REL_BAD, ps, r_item.peer_addr,
                                r_item.group_number, '0, '0, '0, '0);
                            r_q[1] <= mk(trsm_pkg::KIND_SERVICE, ps, r_item.peer_addr,
                                r_item.group_number, '0, '0, '0, '0);
                            r_state[f_peer] <= trsm_pkg::ST_XABORT;
                            n = 2'd2;
                        end
                    end
                    trsm_pkg::ACT_TICK: begin
                        if (tslot_ok) begin
                            unique case (r_state[tslot])
                                trsm_pkg::ST_CTS: begin
                                    r_q[0] <= mk(trsm_pkg::KIND_CTS, r_item.slot,
                                        r_peer[tslot], r_group[tslot], 16'(r_wcnt[tslot]),
                                        r_exp[tslot], '0, '0);
                                    n = 2'd1;
                                    r_seen[tslot] <= 1'b0;
                                    r_state[tslot] <= trsm_pkg::ST_DATA;
                                end
                                trsm_pkg::ST_DATA: begin
                                    if (r_seen[tslot]) begin
                                        r_seen[tslot] <= 1'b0;
                                    end else begin
                                        r_state[tslot] <= trsm_pkg::ST_INACTIVE;
                                        r_q[0] <= mk(trsm_pkg::KIND_REL_BAD, r_item.slot,
                                            r_peer[tslot], r_group[tslot], '0, '0, '0, '0);
                                        r_q[1] <= mk(trsm_pkg::KIND_ABORT, r_item.slot,
                                            r_peer[tslot], r_group[tslot], '0, '0,
                                            trsm_pkg::RSN_TIMEOUT, '0);
                                        n = 2'd2;
                                    end
                                end
                                trsm_pkg::ST_ACK: begin
                                    r_q[0] <= mk(trsm_pkg::KIND_ACK, r_item.slot,
                                        r_peer[tslot], r_group[tslot], r_bytes[tslot],
                                        r_pkts[tslot], '0, '0);
                                    n = 2'd1;
                                    r_state[tslot] <= trsm_pkg::ST_INACTIVE;
                                end
                                trsm_pkg::ST_IABORT: begin
                                    r_q[0] <= mk(trsm_pkg::KIND_ABORT, r_item.slot,
                                        r_peer[tslot], r_group[tslot], '0, '0,
                                        trsm_pkg::RSN_RESOURCE, '0);
                                    n = 2'd1;
                                    r_state[tslot] <= trsm_pkg::ST_INACTIVE;
                                end
                                trsm_pkg::ST_XABORT: r_state[tslot] <= trsm_pkg::ST_INACTIVE;
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
                r_qn <= n;
            end
        end
    end

    always_comb begin
        o_status.has_result = (r_qp < r_qn);
        o_result = r_q[(r_qp == 2'd3) ? 2'd0 : r_qp];
        o_result.last = (r_qp + 2'd1 == r_qn);
    end

endmodule

### hw/rtl/trsm_ctrl.sv
// Controller state machine that sequences capture, evaluation and result transfers.
module trsm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  trsm_pkg::t_status i_status,
    output trsm_pkg::t_cmd    o_cmd
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = i_status.has_result;
                if (!i_status.has_result) begin
                    n_state = S_IDLE;
                end else if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/transport_receive_session_manager.sv
// Receive side of a multi-packet RTS/CTS transport handling up to SESSIONS sessions.
// An item is captured in S_IDLE and evaluated against the session table in the cycle
// after, in S_DECIDE; its results (none to three) then leave in S_EMIT one per cycle
// while the sink is ready. Each item passes through capture, evaluation, one transfer
// per result and a last S_EMIT step that finds the result queue empty; only then can
// a new item be taken. The user must write the accepted group number through
// i_cfg_we / i_cfg_data only while the block is idle; the block does not enforce this.
module transport_receive_session_manager #(
    parameter int SESSIONS = trsm_pkg::SessionsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [17:0] i_cfg_data,
    trsm_in_if.sink     i_in,
    trsm_out_if.source  o_out
);
    logic [17:0]         r_accepted_group;
    trsm_pkg::t_cmd      cmd;
    trsm_pkg::t_status   status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted_group <= trsm_pkg::GroupReset;
        end else if (i_cfg_we) begin
            r_accepted_group <= i_cfg_data;
        end
    end

    trsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    trsm_datapath #(.SESSIONS(SESSIONS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accepted_group (r_accepted_group),
        .i_item           (i_in.payload),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_result         (o_out.payload)
    );

endmodule
